// ===== rtl/rmstat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmstat_pkg
// Widths, command codes and request / result types shared by the running
// measurement statistics block.
// ----------------------------------------------------------------------------
package rmstat_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 16;

    // exact running sum and sum of squares for any count
    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS  = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
    localparam int DEV_BITS = SAMPLE_BITS - 1;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_HOLD   = 2'd2;

    typedef struct packed {
        logic [1:0]                    func;
        logic signed [SAMPLE_BITS-1:0] sample;
    } stat_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] last_value;
        logic signed [SAMPLE_BITS-1:0] min_out;
        logic signed [SAMPLE_BITS-1:0] max_out;
        logic signed [SAMPLE_BITS-1:0] mean_out;
        logic [DEV_BITS-1:0]           deviation_out;
        logic [COUNT_BITS-1:0]         count_out;
        logic                          hold_out;
        logic                          full_out;
    } stat_out_t;

endpackage
`default_nettype wire

// ===== rtl/rmstat_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmstat_div
// Bit-serial restoring divider, one quotient bit per cycle. The quotient
// shifts into the dividend register as the dividend shifts out.
// ----------------------------------------------------------------------------
module rmstat_div
    import rmstat_pkg::*;
#(
    parameter int NUM_BITS = SUM_BITS - 1,
    parameter int DEN_BITS = COUNT_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] dividend,
    input  wire logic [DEN_BITS-1:0] divisor,
    output logic                     busy,
    output logic [NUM_BITS-1:0]      quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] work_reg, work_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = work_reg;

    always_comb
    begin
        trial = {rem_reg, work_reg[NUM_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_BITS'(NUM_BITS);
        end
        else if (busy)
        begin
            work_next = {work_reg[NUM_BITS-2:0], fits};
            rem_next  = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rmstat_sqr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmstat_sqr
// Shift-and-add squarer, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rmstat_sqr
    import rmstat_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] operand,
    output logic                  busy,
    output logic [2*WIDTH-1:0]    product
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic [2*WIDTH-1:0] prod_reg, prod_next;
    logic [WIDTH-1:0]   mcand_reg, mcand_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WIDTH:0]     partial;

    assign busy    = (cnt_reg != '0);
    assign product = prod_reg;

    always_comb
    begin
        partial = {1'b0, prod_reg[2*WIDTH-1:WIDTH]}
                + {1'b0, (prod_reg[0] ? mcand_reg : {WIDTH{1'b0}})};

        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            prod_next  = {{WIDTH{1'b0}}, operand};
            mcand_next = operand;
            cnt_next   = CNT_BITS'(WIDTH);
        end
        else if (busy)
        begin
            prod_next = {partial, prod_reg[WIDTH-1:1]};
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rmstat_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmstat_sqrt
// Digit-by-digit integer square root, one root bit (two radicand bits)
// per cycle.
// ----------------------------------------------------------------------------
module rmstat_sqrt
    import rmstat_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [2*WIDTH-1:0] radicand,
    output logic                    busy,
    output logic [WIDTH-1:0]        root
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic [2*WIDTH-1:0]  x_reg, x_next;
    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    root_reg, root_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WIDTH+1:0]    cur;
    logic [WIDTH+1:0]    trial;
    logic [WIDTH+1:0]    diff;
    logic                ge;

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

    always_comb
    begin
        cur   = {rem_reg, x_reg[2*WIDTH-1:2*WIDTH-2]};
        trial = {root_reg, 2'b01};
        diff  = cur - trial;
        ge    = (cur >= trial);

        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_BITS'(WIDTH);
        end
        else if (busy)
        begin
            x_next    = {x_reg[2*WIDTH-3:0], 2'b00};
            // remainder stays below 2^WIDTH until the last step, whose remainder is unused
            rem_next  = ge ? diff[WIDTH-1:0] : cur[WIDTH-1:0];
            root_next = {root_reg[WIDTH-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule
`default_nettype wire

// ===== rtl/running_measurement_statistics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_measurement_statistics
// Running min, max, mean and standard deviation of gauge samples.
// ----------------------------------------------------------------------------
// Each request is a sample, a clear or a hold toggle; exactly one result
// follows every request. The block works on one request at a time. A clear,
// hold toggle, unused code or ignored sample skips the squaring of the new
// sample, any request that leaves the count at zero skips all bit-serial
// units, and a stalled previous result can hold the new one back. The time
// that an accepted sample takes is set by the bit-serial units: the squarer
// for the new sample, the mean divider and then the squaring of the mean (the
// divider for sum of squares over count runs beside them and finishes first),
// then the square root. The result sits in an output register, so the next
// request is taken while the previous result waits.
// ----------------------------------------------------------------------------
module running_measurement_statistics
    import rmstat_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire stat_in_t  cmd_data,
    output logic           stat_valid,
    input  wire logic      stat_ready,
    output stat_out_t      stat_data
);

    localparam int S        = SAMPLE_BITS;
    localparam int MAG_BITS = SUM_BITS - 1;
    localparam int AVG_BITS = 2 * S - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_DIVIDE,
        ST_ROOT,
        ST_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [S-1:0]     latest_reg, latest_next;
    logic signed [S-1:0]     min_reg, min_next;
    logic signed [S-1:0]     max_reg, max_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SQ_BITS-1:0]      sumsq_reg, sumsq_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    hold_reg, hold_next;
    logic                    full_reg, full_next;
    logic signed [S-1:0]     mean_reg, mean_next;
    logic [DEV_BITS-1:0]     dev_reg, dev_next;
    logic                    msq_started_reg, msq_started_next;
    logic                    stat_valid_reg, stat_valid_next;
    stat_out_t               stat_data_reg, stat_data_next;

    logic signed [S-1:0]     v;
    logic [S-1:0]            abs_v;
    logic [SUM_BITS-1:0]     abs_sum;
    logic [S-1:0]            mean_mag;
    logic [AVG_BITS-1:0]     avg_sq;
    logic [AVG_BITS-1:0]     mean_sq;
    logic [AVG_BITS-1:0]     var_abs;

    logic                    sqr_start, sqr_busy;
    logic [S-1:0]            sqr_op;
    logic [2*S-1:0]          sqr_prod;
    logic                    mdiv_start, mdiv_busy;
    logic [MAG_BITS-1:0]     mdiv_quot;
    logic                    sdiv_start, sdiv_busy;
    logic [SQ_BITS-1:0]      sdiv_quot;
    logic                    root_start, root_busy;
    logic [S-1:0]            root_val;

    assign stat_valid = stat_valid_reg;
    assign stat_data  = stat_data_reg;
    assign cmd_ready  = (state_reg == ST_IDLE);

    assign v        = cmd_data.sample;
    assign abs_v    = v[S-1] ? (S'(0) - v) : v;
    assign abs_sum  = sum_reg[SUM_BITS-1] ? (SUM_BITS'(0) - sum_reg) : sum_reg;
    assign mean_mag = mdiv_quot[S-1:0];
    assign sqr_op   = (state_reg == ST_IDLE) ? abs_v : mean_mag;

    // both averages are at most 2^(2S-2)
    assign avg_sq  = sdiv_quot[AVG_BITS-1:0];
    assign mean_sq = sqr_prod[AVG_BITS-1:0];
    assign var_abs = (avg_sq >= mean_sq) ? (avg_sq - mean_sq) : (mean_sq - avg_sq);

    rmstat_sqr #(
        .WIDTH (S)
    ) u_sqr (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqr_start),
        .operand (sqr_op),
        .busy    (sqr_busy),
        .product (sqr_prod)
    );

    rmstat_div #(
        .NUM_BITS (MAG_BITS),
        .DEN_BITS (COUNT_BITS)
    ) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mdiv_start),
        .dividend (abs_sum[MAG_BITS-1:0]),
        .divisor  (count_reg),
        .busy     (mdiv_busy),
        .quotient (mdiv_quot)
    );

    rmstat_div #(
        .NUM_BITS (SQ_BITS),
        .DEN_BITS (COUNT_BITS)
    ) u_sq_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sdiv_start),
        .dividend (sumsq_reg),
        .divisor  (count_reg),
        .busy     (sdiv_busy),
        .quotient (sdiv_quot)
    );

    rmstat_sqrt #(
        .WIDTH (S)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ({1'b0, var_abs}),
        .busy     (root_busy),
        .root     (root_val)
    );

    always_comb
    begin
        state_next       = state_reg;
        latest_next      = latest_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        sum_next         = sum_reg;
        sumsq_next       = sumsq_reg;
        count_next       = count_reg;
        hold_next        = hold_reg;
        full_next        = full_reg;
        mean_next        = mean_reg;
        dev_next         = dev_reg;
        msq_started_next = msq_started_reg;
        stat_valid_next  = stat_valid_reg;
        stat_data_next   = stat_data_reg;
        sqr_start        = 1'b0;
        mdiv_start       = 1'b0;
        sdiv_start       = 1'b0;
        root_start       = 1'b0;

        if (stat_valid_reg && stat_ready)
        begin
            stat_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_CHECK;
                    unique case (cmd_data.func)
                        FUNC_SAMPLE:
                        begin
                            if (!hold_reg)
                            begin
                                if (&count_reg)
                                begin
                                    full_next = 1'b1;
                                end
                                else
                                begin
                                    latest_next = v;
                                    if (count_reg == '0)
                                    begin
                                        min_next = v;
                                        max_next = v;
                                    end
                                    else
                                    begin
                                        if (v < min_reg)
                                        begin
                                            min_next = v;
                                        end
                                        if (v > max_reg)
                                        begin
                                            max_next = v;
                                        end
                                    end
                                    sum_next   = sum_reg + {{COUNT_BITS{v[S-1]}}, v};
                                    count_next = count_reg + 1'b1;
                                    sqr_start  = 1'b1;
                                    state_next = ST_SQUARE;
                                end
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            min_next   = '0;
                            max_next   = '0;
                            sum_next   = '0;
                            sumsq_next = '0;
                            count_next = '0;
                            full_next  = 1'b0;
                        end
                        FUNC_HOLD:
                        begin
                            hold_next = !hold_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SQUARE:
            begin
                if (!sqr_busy)
                begin
                    sumsq_next = sumsq_reg + {{(SQ_BITS - 2 * S){1'b0}}, sqr_prod};
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (count_reg == '0)
                begin
                    mean_next  = '0;
                    dev_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    mdiv_start       = 1'b1;
                    sdiv_start       = 1'b1;
                    msq_started_next = 1'b0;
                    state_next       = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                // square the mean as soon as it is known, beside the long division
                if (!mdiv_busy && !msq_started_reg)
                begin
                    sqr_start        = 1'b1;
                    msq_started_next = 1'b1;
                end
                if (msq_started_reg && !sqr_busy && !sdiv_busy)
                begin
                    root_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                if (!root_busy)
                begin
                    mean_next  = sum_reg[SUM_BITS-1] ? $signed(S'(0) - mean_mag)
                                                     : $signed(mean_mag);
                    dev_next   = root_val[S-1] ? {DEV_BITS{1'b1}} : root_val[S-2:0];
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!stat_valid_reg || stat_ready)
                begin
                    stat_valid_next              = 1'b1;
                    stat_data_next.last_value    = latest_reg;
                    stat_data_next.min_out       = min_reg;
                    stat_data_next.max_out       = max_reg;
                    stat_data_next.mean_out      = mean_reg;
                    stat_data_next.deviation_out = dev_reg;
                    stat_data_next.count_out     = count_reg;
                    stat_data_next.hold_out      = hold_reg;
                    stat_data_next.full_out      = full_reg;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            latest_reg      <= '0;
            min_reg         <= '0;
            max_reg         <= '0;
            sum_reg         <= '0;
            sumsq_reg       <= '0;
            count_reg       <= '0;
            hold_reg        <= 1'b0;
            full_reg        <= 1'b0;
            mean_reg        <= '0;
            dev_reg         <= '0;
            msq_started_reg <= 1'b0;
            stat_valid_reg  <= 1'b0;
            stat_data_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            latest_reg      <= latest_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
            sum_reg         <= sum_next;
            sumsq_reg       <= sumsq_next;
            count_reg       <= count_next;
            hold_reg        <= hold_next;
            full_reg        <= full_next;
            mean_reg        <= mean_next;
            dev_reg         <= dev_next;
            msq_started_reg <= msq_started_next;
            stat_valid_reg  <= stat_valid_next;
            stat_data_reg   <= stat_data_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rmstat_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmstat_chk
// Port-level checks for the running measurement statistics block.
// ----------------------------------------------------------------------------
module rmstat_chk
    import rmstat_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    input  wire logic      cmd_ready,
    input  wire stat_in_t  cmd_data,
    input  wire logic      stat_valid,
    input  wire logic      stat_ready,
    input  wire stat_out_t stat_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && !stat_ready |=> stat_valid && $stable(stat_data))
        else $error("result changed while stalled");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken while busy");

    // empty statistics read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && (stat_data.count_out == '0) |->
            (stat_data.mean_out == '0) && (stat_data.deviation_out == '0)
            && (stat_data.min_out == '0) && (stat_data.max_out == '0))
        else $error("nonzero statistics with zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid |-> (stat_data.min_out <= stat_data.max_out))
        else $error("minimum above maximum");

    // overflow only with a saturated count
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && stat_data.full_out |-> (&stat_data.count_out))
        else $error("full flag without saturated count");

endmodule

bind running_measurement_statistics rmstat_chk u_rmstat_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .stat_valid (stat_valid),
    .stat_ready (stat_ready),
    .stat_data  (stat_data)
);
`default_nettype wire
